/* sv/pbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared constants, codes and types of the pointer bounds metadata unit.
// ----------------------------------------------------------------------------
package pbm_pkg;

  localparam int INDEX_BITS   = 12;
  localparam int SLOT_DEPTH   = 1 << INDEX_BITS;
  localparam int ENTRY_COUNT  = 1024;
  localparam int ENTRY_IDX_W  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CNT_W        = $clog2(ENTRY_COUNT + 1);
  localparam int SLOT_LSB     = 3;

  localparam logic [2:0] OP_INIT      = 3'd0;
  localparam logic [2:0] OP_PROPAGATE = 3'd1;
  localparam logic [2:0] OP_LOAD      = 3'd2;
  localparam logic [2:0] OP_STORE     = 3'd3;
  localparam logic [2:0] OP_CHECK     = 3'd4;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_VIOLATION   = 2'd1;
  localparam logic [1:0] ST_NO_METADATA = 2'd2;
  localparam logic [1:0] ST_FULL        = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LOOKUP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] bound;
  } bounds_t;

  typedef struct packed {
    logic                   valid;
    logic [ENTRY_IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic clr;
    logic capture;
    logic rd;
    logic ent_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_load;
  } sts_t;

endpackage

/* sv/pbm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_ctrl
// Controller: sequences the clearing pass, the memory reads and the commit.
// ----------------------------------------------------------------------------
module pbm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  pbm_pkg::sts_t sts,
  output pbm_pkg::cmd_t cmd
);

  pbm_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbm_pkg::S_CLEAR: begin
        if (sts.clr_last) state_nxt = pbm_pkg::S_IDLE;
      end
      pbm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pbm_pkg::S_READ;
      end
      pbm_pkg::S_READ: begin
        state_nxt = sts.is_load ? pbm_pkg::S_LOOKUP : pbm_pkg::S_FINISH;
      end
      pbm_pkg::S_LOOKUP: begin
        state_nxt = pbm_pkg::S_FINISH;
      end
      pbm_pkg::S_FINISH: begin
        if (!out_valid_r || !out_stall) state_nxt = pbm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pbm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.clr     = (state_r == pbm_pkg::S_CLEAR);
    cmd.capture = (state_r == pbm_pkg::S_IDLE) && in_valid;
    cmd.rd      = (state_r == pbm_pkg::S_READ);
    cmd.ent_rd  = (state_r == pbm_pkg::S_LOOKUP);
    cmd.commit  = (state_r == pbm_pkg::S_FINISH) && (!out_valid_r || !out_stall);
    in_stall    = (state_r != pbm_pkg::S_IDLE);
    out_valid   = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbm_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/pbm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_dp
// Datapath: slot bounds, slot links and entry store, with the result register.
// ----------------------------------------------------------------------------
module pbm_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  pbm_pkg::cmd_t cmd,
  output pbm_pkg::sts_t sts,
  input  logic [2:0]    in_operation,
  input  logic [63:0]   in_first_pointer,
  input  logic [63:0]   in_second_pointer,
  input  logic [63:0]   in_base_addr,
  input  logic [63:0]   in_bound_addr,
  input  logic [15:0]   in_access_size,
  output logic [1:0]    out_status,
  output logic [63:0]   out_found_base,
  output logic [63:0]   out_found_bound
);

  pbm_pkg::bounds_t bnd_mem [pbm_pkg::SLOT_DEPTH];
  pbm_pkg::link_t   link_mem [pbm_pkg::SLOT_DEPTH];
  pbm_pkg::bounds_t ent_mem [pbm_pkg::ENTRY_COUNT];

  logic [2:0]  op_r;
  logic [63:0] p1_r, p2_r, base_r, bound_r;
  logic [15:0] size_r;

  logic [pbm_pkg::INDEX_BITS-1:0]  clr_r, s1, s2, link_addr;
  logic [pbm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  pbm_pkg::bounds_t                bnd_rd_r, ent_rd_r;
  pbm_pkg::link_t                  link_rd_r;

  logic                            bnd_we, link_we, ent_we;
  logic [pbm_pkg::INDEX_BITS-1:0]  bnd_wa, link_wa;
  logic [pbm_pkg::ENTRY_IDX_W-1:0] ent_wa;
  pbm_pkg::bounds_t                bnd_wd, ent_wd;
  pbm_pkg::link_t                  link_wd;

  logic [1:0]  res_status;
  logic [63:0] res_base, res_bound;
  logic [64:0] end_addr;
  logic        full, bad;

  assign s1        = p1_r[pbm_pkg::SLOT_LSB +: pbm_pkg::INDEX_BITS];
  assign s2        = p2_r[pbm_pkg::SLOT_LSB +: pbm_pkg::INDEX_BITS];
  assign link_addr = (op_r == pbm_pkg::OP_STORE) ? s2 : s1;
  assign full      = (cnt_r == pbm_pkg::CNT_W'(pbm_pkg::ENTRY_COUNT));
  assign end_addr  = 65'(p1_r) + 65'(size_r);
  assign bad       = (p1_r < bnd_rd_r.base) || (end_addr > 65'(bnd_rd_r.bound));

  assign sts.clr_last = (clr_r == {pbm_pkg::INDEX_BITS{1'b1}});
  assign sts.is_load  = (op_r == pbm_pkg::OP_LOAD);

  always_comb begin
    bnd_we     = 1'b0;
    bnd_wa     = s2;
    bnd_wd     = bnd_rd_r;
    link_we    = 1'b0;
    link_wa    = s1;
    link_wd    = '{valid: 1'b1, idx: cnt_r[pbm_pkg::ENTRY_IDX_W-1:0]};
    ent_we     = 1'b0;
    ent_wa     = cnt_r[pbm_pkg::ENTRY_IDX_W-1:0];
    ent_wd     = '{base: base_r, bound: bound_r};
    cnt_nxt    = cnt_r;
    res_status = pbm_pkg::ST_OK;
    res_base   = '0;
    res_bound  = '0;
    if (cmd.clr) begin
      bnd_we  = 1'b1;
      bnd_wa  = clr_r;
      bnd_wd  = '0;
      link_we = 1'b1;
      link_wa = clr_r;
      link_wd = '0;
    end else if (cmd.commit) begin
      case (op_r)
        pbm_pkg::OP_INIT: begin
          if (full) begin
            res_status = pbm_pkg::ST_FULL;
          end else begin
            ent_we    = 1'b1;
            bnd_we    = 1'b1;
            bnd_wa    = s1;
            bnd_wd    = '{base: base_r, bound: bound_r};
            link_we   = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            res_base  = base_r;
            res_bound = bound_r;
          end
        end
        pbm_pkg::OP_PROPAGATE: begin
          bnd_we    = 1'b1;
          res_base  = bnd_rd_r.base;
          res_bound = bnd_rd_r.bound;
        end
        pbm_pkg::OP_LOAD: begin
          if (!link_rd_r.valid) begin
            res_status = pbm_pkg::ST_NO_METADATA;
          end else begin
            bnd_we    = 1'b1;
            bnd_wd    = ent_rd_r;
            res_base  = ent_rd_r.base;
            res_bound = ent_rd_r.bound;
          end
        end
        pbm_pkg::OP_STORE: begin
          if (!link_rd_r.valid) begin
            res_status = pbm_pkg::ST_NO_METADATA;
          end else begin
            ent_we    = 1'b1;
            ent_wa    = link_rd_r.idx;
            ent_wd    = bnd_rd_r;
            res_base  = bnd_rd_r.base;
            res_bound = bnd_rd_r.bound;
          end
        end
        pbm_pkg::OP_CHECK: begin
          res_status = bad ? pbm_pkg::ST_VIOLATION : pbm_pkg::ST_OK;
          res_base   = bnd_rd_r.base;
          res_bound  = bnd_rd_r.bound;
        end
        default: begin
          res_status = pbm_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_we) bnd_mem[bnd_wa] <= bnd_wd;
    if (cmd.rd) bnd_rd_r <= bnd_mem[s1];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (cmd.rd) link_rd_r <= link_mem[link_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (cmd.ent_rd) ent_rd_r <= ent_mem[link_rd_r.idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      p1_r    <= in_first_pointer;
      p2_r    <= in_second_pointer;
      base_r  <= in_base_addr;
      bound_r <= in_bound_addr;
      size_r  <= in_access_size;
    end
    if (cmd.commit) begin
      out_status      <= res_status;
      out_found_base  <= res_base;
      out_found_bound <= res_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sv/pointer_bounds_metadata_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_bounds_metadata_unit_top
// Pointer bounds metadata unit: slot bounds, slot links and an entry store.
// ----------------------------------------------------------------------------
// Sequence: the item is captured, the slot bounds and links are read, a load
// then reads the entry store, and the commit registers the result.
// A new item is taken only after the previous one has committed; the next item
// is taken while a result waits, but a held result stalls the next commit.
// Reset: a clearing pass zeroes the slot bounds and link tables;
// in_stall stays high until it finishes.
// ----------------------------------------------------------------------------
module pointer_bounds_metadata_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_first_pointer,
  input  logic [63:0] in_second_pointer,
  input  logic [63:0] in_base_addr,
  input  logic [63:0] in_bound_addr,
  input  logic [15:0] in_access_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_found_base,
  output logic [63:0] out_found_bound
);

  pbm_pkg::cmd_t cmd;
  pbm_pkg::sts_t sts;

  pbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_first_pointer  (in_first_pointer),
    .in_second_pointer (in_second_pointer),
    .in_base_addr      (in_base_addr),
    .in_bound_addr     (in_bound_addr),
    .in_access_size    (in_access_size),
    .out_status        (out_status),
    .out_found_base    (out_found_base),
    .out_found_bound   (out_found_bound)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pointer bounds metadata unit. A directed table
// walks reset values, pointer and size extremes, unlinked slots, unused codes
// and bounds arithmetic at the 64-bit edge. Random items follow, mostly
// init-then-use sequences on a few busy slots, under several idling mixes and
// a long receiver hold-off. Each result is compared field by field, typed
// rows with the table's values, others with an in-bench shadow of the tables.
// ----------------------------------------------------------------------------
module tb_top;
  import pbm_pkg::*;

  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int HOT_SLOTS = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES = 250000;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] first_ptr;
    logic [63:0] second_ptr;
    logic [63:0] base;
    logic [63:0] bound;
    logic [15:0] size;
  } metadata_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] base;
    logic [63:0] bound;
  } metadata_result_t;

  typedef struct packed {
    metadata_req_t    req;
    logic             typed;
    metadata_result_t want;
  } stimulus_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_operation;
  logic [63:0] in_first_pointer;
  logic [63:0] in_second_pointer;
  logic [63:0] in_base_addr;
  logic [63:0] in_bound_addr;
  logic [15:0] in_access_size;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [63:0] out_found_base;
  logic [63:0] out_found_bound;

  pointer_bounds_metadata_unit_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_first_pointer (in_first_pointer),
    .in_second_pointer(in_second_pointer),
    .in_base_addr     (in_base_addr),
    .in_bound_addr    (in_bound_addr),
    .in_access_size   (in_access_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found_base   (out_found_base),
    .out_found_bound  (out_found_bound)
  );

  logic [63:0]            shadow_slot_base  [SLOT_DEPTH];
  logic [63:0]            shadow_slot_bound [SLOT_DEPTH];
  logic                   shadow_slot_linked[SLOT_DEPTH];
  logic [ENTRY_IDX_W-1:0] shadow_slot_entry [SLOT_DEPTH];
  logic [63:0]            shadow_entry_base [ENTRY_COUNT];
  logic [63:0]            shadow_entry_bound[ENTRY_COUNT];
  int unsigned            entries_used;

  metadata_result_t       pending_results[$];
  stimulus_row_t          directed_rows[$];
  logic [63:0]            live_ptrs[$];
  logic [INDEX_BITS-1:0]  hot_slots[HOT_SLOTS];

  int send_gap_pct;
  int recv_stall_pct;
  logic hold_request;
  int hold_left;
  int cycle_count;
  int error_count;
  int results_checked;
  int op_count[8];
  int status_count[4];

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

  function automatic metadata_result_t apply_metadata_op(input metadata_req_t r);
    metadata_result_t res;
    logic [INDEX_BITS-1:0] s1;
    logic [INDEX_BITS-1:0] s2;
    logic [ENTRY_IDX_W-1:0] e;
    logic [64:0] end_sum;
    s1 = r.first_ptr[SLOT_LSB +: INDEX_BITS];
    s2 = r.second_ptr[SLOT_LSB +: INDEX_BITS];
    res = '0;
    res.status = ST_OK;
    case (r.op)
      OP_INIT: begin
        if (entries_used >= ENTRY_COUNT) begin
          res.status = ST_FULL;
        end else begin
          e = entries_used[ENTRY_IDX_W-1:0];
          entries_used++;
          shadow_entry_base[e] = r.base;
          shadow_entry_bound[e] = r.bound;
          shadow_slot_base[s1] = r.base;
          shadow_slot_bound[s1] = r.bound;
          shadow_slot_linked[s1] = 1'b1;
          shadow_slot_entry[s1] = e;
          res.base = r.base;
          res.bound = r.bound;
        end
      end
      OP_PROPAGATE: begin
        res.base = shadow_slot_base[s1];
        res.bound = shadow_slot_bound[s1];
        shadow_slot_base[s2] = res.base;
        shadow_slot_bound[s2] = res.bound;
      end
      OP_LOAD: begin
        if (!shadow_slot_linked[s1]) begin
          res.status = ST_NO_METADATA;
        end else begin
          e = shadow_slot_entry[s1];
          res.base = shadow_entry_base[e];
          res.bound = shadow_entry_bound[e];
          shadow_slot_base[s2] = res.base;
          shadow_slot_bound[s2] = res.bound;
        end
      end
      OP_STORE: begin
        if (!shadow_slot_linked[s2]) begin
          res.status = ST_NO_METADATA;
        end else begin
          e = shadow_slot_entry[s2];
          res.base = shadow_slot_base[s1];
          res.bound = shadow_slot_bound[s1];
          shadow_entry_base[e] = res.base;
          shadow_entry_bound[e] = res.bound;
        end
      end
      OP_CHECK: begin
        res.base = shadow_slot_base[s1];
        res.bound = shadow_slot_bound[s1];
        end_sum = {1'b0, r.first_ptr} + {49'd0, r.size};
        if (r.first_ptr < res.base || end_sum > {1'b0, res.bound}) begin
          res.status = ST_VIOLATION;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_pointer();
    int unsigned sel;
    logic [63:0] p;
    sel = $urandom_range(99);
    p = rand64();
    if (sel < 55 && live_ptrs.size() != 0) begin
      p = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
      if ($urandom_range(1) == 1) begin
        p[2:0] = 3'($urandom_range(7));
      end
    end else if (sel < 90) begin
      p[SLOT_LSB +: INDEX_BITS] = hot_slots[$urandom_range(HOT_SLOTS - 1)];
    end
    return p;
  endfunction

  function automatic metadata_req_t noise_request();
    metadata_req_t r;
    r.op = 3'($urandom_range(7));
    r.first_ptr = rand64();
    r.second_ptr = rand64();
    r.base = rand64();
    r.bound = rand64();
    r.size = 16'($urandom_range(16'hFFFF));
    return r;
  endfunction

  function automatic metadata_req_t init_request();
    metadata_req_t r;
    r = noise_request();
    r.op = OP_INIT;
    r.first_ptr = pick_pointer();
    if ($urandom_range(9) != 0) begin
      r.base = r.first_ptr - 64'($urandom_range(255));
      r.bound = r.first_ptr + 64'($urandom_range(16'h4000, 1));
    end
    live_ptrs.push_back(r.first_ptr);
    if (live_ptrs.size() > 16) begin
      void'(live_ptrs.pop_front());
    end
    return r;
  endfunction

  function automatic metadata_req_t random_request();
    metadata_req_t r;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 22) begin
      return init_request();
    end
    r = noise_request();
    r.first_ptr = pick_pointer();
    if (sel < 36) begin
      r.op = OP_PROPAGATE;
      r.second_ptr = pick_pointer();
    end else if (sel < 50) begin
      r.op = OP_LOAD;
      r.second_ptr = pick_pointer();
    end else if (sel < 64) begin
      r.op = OP_STORE;
      r.second_ptr = pick_pointer();
    end else if (sel < 94) begin
      r.op = OP_CHECK;
      if ($urandom_range(1) == 1) begin
        r.size = 16'($urandom_range(64));
      end
    end else begin
      case ($urandom_range(2))
        0: r.op = OP_RSVD_A;
        1: r.op = OP_RSVD_B;
        default: r.op = OP_RSVD_C;
      endcase
    end
    return r;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [63:0] p1, input logic [63:0] p2,
                         input logic [63:0] base, input logic [63:0] bound,
                         input logic [15:0] size, input logic typed,
                         input logic [1:0] st, input logic [63:0] fb,
                         input logic [63:0] fbd);
    stimulus_row_t row;
    row.req = '{op, p1, p2, base, bound, size};
    row.typed = typed;
    row.want = '{st, fb, fbd};
    directed_rows.push_back(row);
  endtask

  // Enters and leaves at a falling edge.
  task automatic send_item(input metadata_req_t r, input logic typed,
                           input metadata_result_t want);
    metadata_result_t predicted;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= r.op;
    in_first_pointer <= r.first_ptr;
    in_second_pointer <= r.second_ptr;
    in_base_addr <= r.base;
    in_bound_addr <= r.bound;
    in_access_size <= r.size;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = apply_metadata_op(r);
    pending_results.push_back(typed ? want : predicted);
    op_count[r.op]++;
    status_count[predicted.status]++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic run_random(input int count, input int gap_pct, input int stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_item(random_request(), 1'b0, '0);
    end
    wait_for_results();
  endtask

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_checker
    metadata_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: status %0d, base %h, bound %h", $time,
                 out_status, out_found_base, out_found_bound);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_status !== want.status) begin
          error_count++;
          $display("%0t: status mismatch: expected %0d, got %0d", $time,
                   want.status, out_status);
        end
        if (out_found_base !== want.base) begin
          error_count++;
          $display("%0t: found_base mismatch: expected %h, got %h", $time,
                   want.base, out_found_base);
        end
        if (out_found_bound !== want.bound) begin
          error_count++;
          $display("%0t: found_bound mismatch: expected %h, got %h", $time,
                   want.bound, out_found_bound);
        end
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_INIT;
    in_first_pointer = '0;
    in_second_pointer = '0;
    in_base_addr = '0;
    in_bound_addr = '0;
    in_access_size = '0;
    hold_request = 1'b0;
    hold_left = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    results_checked = 0;
    entries_used = 0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;
    for (int i = 0; i < SLOT_DEPTH; i++) begin
      shadow_slot_base[i] = '0;
      shadow_slot_bound[i] = '0;
      shadow_slot_linked[i] = 1'b0;
      shadow_slot_entry[i] = '0;
    end
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      shadow_entry_base[i] = '0;
      shadow_entry_bound[i] = '0;
    end
    hot_slots[0] = '0;
    hot_slots[1] = '1;
    for (int i = 2; i < HOT_SLOTS; i++) begin
      hot_slots[i] = INDEX_BITS'($urandom_range(SLOT_DEPTH - 1));
    end

    add_row(OP_CHECK, 64'h0, 64'h0, 64'h0, 64'h0, 16'h0, 1'b1, ST_OK, 64'h0, 64'h0);
    add_row(OP_CHECK, 64'h0, 64'h0, 64'h0, 64'h0, 16'h1, 1'b1, ST_VIOLATION, 64'h0, 64'h0);
    add_row(OP_LOAD, 64'h1000, 64'h2000, 64'h0, 64'h0, 16'h0, 1'b1, ST_NO_METADATA,
            64'h0, 64'h0);
    add_row(OP_STORE, 64'h0, 64'h1000, 64'h0, 64'h0, 16'h0, 1'b1, ST_NO_METADATA,
            64'h0, 64'h0);
    add_row(OP_RSVD_A, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 16'hFFFF, 1'b1, ST_OK,
            64'h0, 64'h0);
    add_row(OP_RSVD_B, 64'h1000, 64'h1000, 64'h1, 64'h2, 16'h1, 1'b1, ST_OK, 64'h0, 64'h0);
    add_row(OP_RSVD_C, ALL_ONES, 64'h0, ALL_ONES, 64'h0, 16'hFFFF, 1'b1, ST_OK,
            64'h0, 64'h0);
    add_row(OP_INIT, ALL_ONES, 64'h0, 64'h0, ALL_ONES, 16'h0, 1'b1, ST_OK, 64'h0, ALL_ONES);
    add_row(OP_CHECK, ALL_ONES, 64'h0, 64'h0, 64'h0, 16'h0, 1'b1, ST_OK, 64'h0, ALL_ONES);
    add_row(OP_CHECK, ALL_ONES, 64'h0, 64'h0, 64'h0, 16'hFFFF, 1'b1, ST_VIOLATION,
            64'h0, ALL_ONES);
    add_row(OP_CHECK, 64'h0, 64'h0, 64'h0, 64'h0, 16'hFFFF, 1'b1, ST_VIOLATION,
            64'h0, 64'h0);
    add_row(OP_INIT, 64'h1000, 64'h0, 64'h1000, 64'h1040, 16'h0, 1'b1, ST_OK,
            64'h1000, 64'h1040);
    add_row(OP_CHECK, 64'h1004, 64'h0, 64'h0, 64'h0, 16'h3C, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_CHECK, 64'h1004, 64'h0, 64'h0, 64'h0, 16'h3D, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_PROPAGATE, 64'h1000, 64'h2000, 64'h0, 64'h0, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_CHECK, 64'h2000, 64'h0, 64'h0, 64'h0, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_LOAD, 64'h1000, 64'h3000, 64'h0, 64'h0, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_STORE, ALL_ONES, 64'h1000, 64'h0, 64'h0, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_LOAD, 64'h1000, 64'h4008, 64'h0, 64'h0, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_CHECK, 64'h1000, 64'h0, 64'h0, 64'h0, 16'h10, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_INIT, 64'h5000, 64'h0, 64'h6000, 64'h5000, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_CHECK, 64'h5000, 64'h0, 64'h0, 64'h0, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_PROPAGATE, 64'h7000, 64'h1000, 64'h0, 64'h0, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_STORE, 64'h1000, 64'h1000, 64'h0, 64'h0, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);
    add_row(OP_LOAD, ALL_ONES, ALL_ONES, 64'h0, 64'h0, 16'h0, 1'b0, ST_OK, 64'h0, 64'h0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_for_results();

    run_random(80, 0, 0);
    run_random(80, 60, 0);
    run_random(80, 0, 60);
    run_random(80, 20, 20);

    // Hold the result side long enough for the unit to back up into its input.
    hold_request = 1'b1;
    run_random(40, 0, 0);

    run_random(20, 20, 20);

    repeat (10) @(posedge clk);
    $display("Items: %0d init, %0d propagate, %0d load, %0d store, %0d check, %0d unused.",
             op_count[OP_INIT], op_count[OP_PROPAGATE], op_count[OP_LOAD],
             op_count[OP_STORE], op_count[OP_CHECK],
             op_count[OP_RSVD_A] + op_count[OP_RSVD_B] + op_count[OP_RSVD_C]);
    $display("Results: %0d checked, %0d ok, %0d out of bounds, %0d unlinked, %0d full.",
             results_checked, status_count[ST_OK], status_count[ST_VIOLATION],
             status_count[ST_NO_METADATA], status_count[ST_FULL]);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
